// ===== hdl/rmts_pkg.sv =====
// Package for the rate monotonic tick scheduler: request codes, payload
// structs, controller command/status types and a helper function.
// No dependencies.
`default_nettype none
package rmts_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_STATS = 2'd2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  task_slot;
        logic        periodic;
        logic [15:0] period;
        logic [15:0] budget;
        logic [30:0] release_tick;
        logic [30:0] first_deadline;
    } req_t;

    typedef struct packed {
        logic [30:0] time_now;
        logic [2:0]  running_slot;
        logic        cpu_idle;
        logic        task_started;
        logic        preempt_flag;
        logic [2:0]  preempted_slot;
        logic        task_done;
        logic [7:0]  missed_mask;
        logic [15:0] preempt_count;
        logic [15:0] missed_count;
        logic [30:0] resp_ticks;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOAD, S_SCAN, S_PREEMPT, S_RUN, S_DL, S_STATS, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_SCAN, OP_PREEMPT, OP_RUN, OP_DEADLINE, OP_STATS, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_kind;
        logic       out_free;
    } stat_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rmts_if.sv =====
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on rmts_pkg.
`default_nettype none
interface rmts_req_if;
    logic              valid;
    logic              ready;
    rmts_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmts_res_if;
    logic              valid;
    logic              ready;
    rmts_pkg::res_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rmts_ctrl.sv =====
// Scheduler sequencer: walks each request through its steps and drives
// the datapath with commands and a slot step counter. Depends on rmts_pkg.
`default_nettype none
module rmts_ctrl #(
    parameter int TASK_SLOTS = 8,
    parameter int SW = 3
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire rmts_pkg::stat_t stat,
    output rmts_pkg::cmd_t       cmd,
    output logic [SW-1:0]        step,
    output logic                 in_ready
);
    import rmts_pkg::*;

    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

    state_t        state_reg, state_next;
    logic [SW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.last   = (cnt_reg == LAST);
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cnt_next = '0;
                unique case (stat.req_kind)
                    REQ_LOAD:  state_next = S_LOAD;
                    REQ_TICK:  state_next = S_SCAN;
                    REQ_STATS: state_next = S_STATS;
                    default:   state_next = S_FIN;
                endcase
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (cmd.last)
                begin
                    cnt_next   = '0;
                    state_next = S_PREEMPT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PREEMPT:
            begin
                cmd.op     = OP_PREEMPT;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.op     = OP_RUN;
                state_next = S_DL;
            end
            S_DL:
            begin
                cmd.op = OP_DEADLINE;
                if (cmd.last)
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_STATS:
            begin
                cmd.op     = OP_STATS;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FINISH;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign step = cnt_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready) else $error("ready while request in flight");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SCAN || cmd.op == OP_DEADLINE) |-> (cnt_reg <= LAST))
        else $error("slot step out of range");
    a_fin_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== hdl/rmts_datapath.sv =====
// Scheduler datapath: task table, selection registers, per-step updates and
// the result output register. Depends on rmts_pkg.
`default_nettype none
module rmts_datapath #(
    parameter int TASK_SLOTS = 8,
    parameter int SW = 3
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rmts_pkg::cmd_t  cmd,
    input  wire logic [SW-1:0]   step,
    input  wire logic            accept,
    input  wire rmts_pkg::req_t  req_in,
    output rmts_pkg::stat_t      stat,
    output rmts_pkg::res_t       res_data,
    output logic                 res_valid,
    input  wire logic            res_ready
);
    import rmts_pkg::*;

    // slot table
    logic        v_reg   [TASK_SLOTS];
    logic [15:0] pc_reg  [TASK_SLOTS];
    logic [15:0] mc_reg  [TASK_SLOTS];
    logic        per_reg [TASK_SLOTS];
    logic [15:0] prd_reg [TASK_SLOTS];
    logic [15:0] bud_reg [TASK_SLOTS];
    logic [15:0] rem_reg [TASK_SLOTS];
    logic [30:0] rel_reg [TASK_SLOTS];
    logic [30:0] dl_reg  [TASK_SLOTS];
    logic [30:0] fin_reg [TASK_SLOTS];

    req_t          req_reg;
    res_t          work_reg, out_reg;
    res_t          work_init;
    logic          out_valid_reg;
    logic [30:0]   time_reg;
    logic          cur_v_reg, fmark_reg;
    logic [SW-1:0] cur_reg;
    logic          bp_v_reg, ba_v_reg;
    logic [SW-1:0] bp_slot_reg, ba_slot_reg;
    logic [15:0]   bp_key_reg;
    logic [30:0]   ba_key_reg;

    logic [SW-1:0] idx, pick, slot_idx;
    logic          pick_v, slot_ok, out_free;
    logic          r_v, r_per;
    logic [15:0]   r_prd, r_bud, r_rem, r_pc, r_mc, rem_dec;
    logic [30:0]   r_rel, r_dl, r_fin;
    logic          cand_p, cand_a, dl_hit, do_preempt;

    assign pick_v   = bp_v_reg | ba_v_reg;
    assign pick     = bp_v_reg ? bp_slot_reg : ba_slot_reg;
    assign slot_idx = SW'(req_reg.task_slot);
    assign slot_ok  = (32'(req_reg.task_slot) < TASK_SLOTS);
    assign out_free = !out_valid_reg || res_ready;

    // fresh result: tick count now, everything else zero
    always_comb
    begin
        work_init          = '0;
        work_init.time_now = time_reg;
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_SCAN, OP_DEADLINE: idx = step;
            OP_PREEMPT:           idx = cur_reg;
            OP_RUN:               idx = pick;
            default:              idx = slot_idx;
        endcase
    end

    assign r_v   = v_reg[idx];
    assign r_per = per_reg[idx];
    assign r_prd = prd_reg[idx];
    assign r_bud = bud_reg[idx];
    assign r_rem = rem_reg[idx];
    assign r_rel = rel_reg[idx];
    assign r_dl  = dl_reg[idx];
    assign r_fin = fin_reg[idx];
    assign r_pc  = pc_reg[idx];
    assign r_mc  = mc_reg[idx];
    assign rem_dec = r_rem - 16'd1;

    assign cand_p = r_v && r_per && (r_rem != 16'd0) && (!bp_v_reg || r_prd < bp_key_reg);
    assign cand_a = r_v && !r_per && (r_rem != 16'd0) && (time_reg >= r_rel)
                    && (!ba_v_reg || r_rel < ba_key_reg);
    assign dl_hit = r_v && (({1'b0, time_reg} + 32'd1) == {1'b0, r_dl});
    assign do_preempt = cur_v_reg && (!pick_v || cur_reg != pick) && !fmark_reg;

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                v_reg[i]  <= 1'b0;
                pc_reg[i] <= '0;
                mc_reg[i] <= '0;
            end
            req_reg       <= '0;
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            cur_v_reg     <= 1'b0;
            cur_reg       <= '0;
            fmark_reg     <= 1'b0;
            bp_v_reg      <= 1'b0;
            ba_v_reg      <= 1'b0;
            bp_slot_reg   <= '0;
            ba_slot_reg   <= '0;
            bp_key_reg    <= '0;
            ba_key_reg    <= '0;
        end
        else
        begin
            // a new result may load in the same cycle the old one leaves
            if (cmd.op == OP_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (res_valid && res_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                req_reg  <= req_in;
                bp_v_reg <= 1'b0;
                ba_v_reg <= 1'b0;
                work_reg <= work_init;
            end
            unique case (cmd.op)
                OP_SCAN:
                begin
                    if (cand_p)
                    begin
                        bp_v_reg    <= 1'b1;
                        bp_slot_reg <= idx;
                        bp_key_reg  <= r_prd;
                    end
                    if (cand_a)
                    begin
                        ba_v_reg    <= 1'b1;
                        ba_slot_reg <= idx;
                        ba_key_reg  <= r_rel;
                    end
                end
                OP_PREEMPT:
                begin
                    if (do_preempt)
                    begin
                        pc_reg[idx]             <= sat_inc16(r_pc);
                        work_reg.preempt_flag   <= 1'b1;
                        work_reg.preempted_slot <= 3'(cur_reg);
                    end
                    work_reg.task_started <= pick_v && (!cur_v_reg || cur_reg != pick);
                    cur_v_reg <= pick_v;
                    cur_reg   <= pick;
                end
                OP_RUN:
                begin
                    if (pick_v)
                    begin
                        work_reg.running_slot <= 3'(pick);
                        work_reg.task_done    <= (rem_dec == 16'd0);
                        fmark_reg             <= (rem_dec == 16'd0);
                    end
                    else
                        work_reg.cpu_idle <= 1'b1;
                end
                OP_DEADLINE:
                begin
                    if (dl_hit && r_rem != 16'd0)
                    begin
                        mc_reg[idx] <= sat_inc16(r_mc);
                        fmark_reg   <= 1'b1;
                        if (32'(idx) < 32'd8)
                            work_reg.missed_mask[3'(idx)] <= 1'b1;
                    end
                    if (cmd.last)
                        time_reg <= time_reg + 31'd1;
                end
                OP_LOAD:
                begin
                    if (slot_ok)
                    begin
                        v_reg[idx]  <= 1'b1;
                        pc_reg[idx] <= '0;
                        mc_reg[idx] <= '0;
                    end
                end
                OP_STATS:
                begin
                    if (slot_ok && r_v)
                    begin
                        work_reg.preempt_count <= r_pc;
                        work_reg.missed_count  <= r_mc;
                        if (!r_per && r_fin >= r_rel)
                            work_reg.resp_ticks <= r_fin - r_rel;
                    end
                end
                default: ;
            endcase
        end
    end

    // task fields and output payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_RUN:
            begin
                if (pick_v)
                begin
                    rem_reg[idx] <= rem_dec;
                    if (rem_dec == 16'd0 && !r_per)
                        fin_reg[idx] <= time_reg;
                end
            end
            OP_DEADLINE:
            begin
                if (dl_hit)
                begin
                    if (r_rem != 16'd0 && !r_per)
                        fin_reg[idx] <= time_reg;
                    if (r_per)
                    begin
                        rem_reg[idx] <= r_bud;
                        dl_reg[idx]  <= r_dl + {15'd0, r_prd};
                    end
                    else
                        rem_reg[idx] <= '0;
                end
            end
            OP_LOAD:
            begin
                if (slot_ok)
                begin
                    per_reg[idx] <= req_reg.periodic;
                    prd_reg[idx] <= req_reg.period;
                    bud_reg[idx] <= req_reg.budget;
                    rem_reg[idx] <= req_reg.budget;
                    rel_reg[idx] <= req_reg.release_tick;
                    dl_reg[idx]  <= req_reg.first_deadline;
                    fin_reg[idx] <= req_reg.release_tick;
                end
            end
            OP_FINISH:
            begin
                if (out_free)
                    out_reg <= work_reg;
            end
            default: ;
        endcase
    end

    assign stat.req_kind = req_reg.req_type;
    assign stat.out_free = out_free;
    assign res_data      = out_reg;
    assign res_valid     = out_valid_reg;

`ifndef SYNTH
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH && out_free) |=> res_valid)
        else $error("result not presented");
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RUN && pick_v) |-> (r_rem != 16'd0))
        else $error("picked task with no work left");
    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RUN && pick_v) |-> r_v)
        else $error("picked unloaded slot");
`endif

endmodule
`default_nettype wire

// ===== hdl/rate_monotonic_tick_scheduler_top.sv =====
// From accept to result valid, a load runs decode, load, finish; a stats read
// runs decode, stats, finish; a tick runs decode, slot scan, preempt, run,
// deadline sweep, finish; scan and sweep go one slot per cycle. One at a time;
// a result waiting in the output register holds the sequencer in finish.
// Reset (rst_n low, async): table empty, counters zero, no current task,
// tick count zero, no result pending.
`default_nettype none
module rate_monotonic_tick_scheduler_top #(
    parameter int TASK_SLOTS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rmts_req_if.sink  req,
    rmts_res_if.source res
);
    import rmts_pkg::*;

    // slot index width, at least one bit
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    cmd_t          cmd;
    stat_t         stat;
    logic [SW-1:0] step;
    logic          in_ready;
    logic          accept;

    // a transaction is taken only while the sequencer is idle
    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // sequencer: decode; load, stats or scan/preempt/run/deadline sweep; finish
    rmts_ctrl #(
        .TASK_SLOTS (TASK_SLOTS),
        .SW         (SW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .stat     (stat),
        .cmd      (cmd),
        .step     (step),
        .in_ready (in_ready)
    );

    // task table and result register
    rmts_datapath #(
        .TASK_SLOTS (TASK_SLOTS),
        .SW         (SW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .step      (step),
        .accept    (accept),
        .req_in    (req.data),
        .stat      (stat),
        .res_data  (res.data),
        .res_valid (res.valid),
        .res_ready (res.ready)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NONE) |-> !accept) else $error("accept during work");
    a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH && stat.out_free) |=> res.valid)
        else $error("finished transaction lost");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(cmd.op == OP_FINISH))
        else $error("ready without finishing");
`endif

endmodule
`default_nettype wire
